FILE: sv/rbst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, types and helpers for the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBits    = 16;
  localparam int QuotWidth   = CoordWidth + 1;
  localparam int DivdWidth   = CoordWidth + 1 + FracBits;
  localparam int NumLanes    = 6;
  localparam int NumAxes     = 3;
  localparam int NumDivSteps = QuotWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;

  // One plane divider lane; acc shifts dividend bits out and quotient bits in.
  typedef struct packed {
    logic                  neg;
    logic                  ovf;
    logic [CoordWidth-1:0] den;
    logic [CoordWidth-1:0] rem;
    logic [QuotWidth-1:0]  acc;
  } lane_t;

  typedef struct packed {
    logic zero;
    logic in_range;
  } axis_t;

  // Lane 2k is the low plane of axis k, lane 2k+1 the high plane.
  typedef struct packed {
    lane_t [NumLanes-1:0] lane;
    axis_t [NumAxes-1:0]  axis;
  } pipe_t;

  function automatic lane_t div_step(lane_t l);
    logic [CoordWidth:0] part;
    logic [CoordWidth:0] diff;
    logic                qb;
    lane_t               o;
    o    = l;
    part = {l.rem, l.acc[QuotWidth-1]};
    diff = part - {1'b0, l.den};
    qb   = (part >= {1'b0, l.den});
    o.rem = qb ? diff[CoordWidth-1:0] : part[CoordWidth-1:0];
    o.acc = {l.acc[QuotWidth-2:0], qb};
    return o;
  endfunction

endpackage : rbst_pkg
`default_nettype wire

FILE: sv/rbst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_req_if / rbst_rsp_if
// Valid/ready channels carrying a ray/box request and its hit response.
// ----------------------------------------------------------------------------
interface rbst_req_if;
  import rbst_pkg::*;
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  coord_t box_low_x;
  coord_t box_low_y;
  coord_t box_low_z;
  coord_t box_high_x;
  coord_t box_high_y;
  coord_t box_high_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_low_x, box_low_y, box_low_z, box_high_x, box_high_y, box_high_z,
    output ready
  );
endinterface : rbst_req_if

interface rbst_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface : rbst_rsp_if
`default_nettype wire

FILE: sv/rbst_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_prep
// Forms plane offsets, magnitudes, signs and overflow flags for six dividers.
// ----------------------------------------------------------------------------
module rbst_prep (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire rbst_pkg::coord_t origin_i [3],
  input  wire rbst_pkg::coord_t dir_i    [3],
  input  wire rbst_pkg::coord_t low_i    [3],
  input  wire rbst_pkg::coord_t high_i   [3],
  output rbst_pkg::pipe_t       stage_o
);
  import rbst_pkg::*;

  pipe_t stage_d, stage_q;

  always_comb begin
    logic signed [CoordWidth:0] diff;
    logic [CoordWidth:0]        mag;
    logic                       pneg;
    logic                       dneg;
    logic [CoordWidth-1:0]      den;
    logic [DivdWidth-1:0]       divd;
    logic [CoordWidth+QuotWidth-1:0] lhs;
    coord_t                     plane;
    stage_d = '0;
    for (int k = 0; k < NumAxes; k++) begin
      stage_d.axis[k].zero     = (dir_i[k] == '0);
      stage_d.axis[k].in_range = (origin_i[k] >= low_i[k]) && (origin_i[k] <= high_i[k]);
      dneg = dir_i[k][CoordWidth-1];
      den  = dneg ? (CoordWidth'(0) - dir_i[k]) : dir_i[k];
      for (int p = 0; p < 2; p++) begin
        plane = (p == 0) ? low_i[k] : high_i[k];
        diff  = (CoordWidth+1)'(plane) - (CoordWidth+1)'(origin_i[k]);
        pneg  = diff[CoordWidth];
        mag   = pneg ? ((CoordWidth+1)'(0) - diff) : diff;
        divd  = DivdWidth'({mag, {FracBits{1'b0}}});
        lhs   = (CoordWidth+QuotWidth)'(divd);
        stage_d.lane[2*k+p].neg = pneg ^ dneg;
        // quotient needs more than QuotWidth bits: saturate
        stage_d.lane[2*k+p].ovf = (lhs >= {den, {QuotWidth{1'b0}}});
        stage_d.lane[2*k+p].den = den;
        stage_d.lane[2*k+p].rem = CoordWidth'(divd >> QuotWidth);
        stage_d.lane[2*k+p].acc = divd[QuotWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule : rbst_prep
`default_nettype wire

FILE: sv/rbst_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_div_step
// One restoring division step for all six lanes, registered.
// ----------------------------------------------------------------------------
module rbst_div_step (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire rbst_pkg::pipe_t stage_i,
  output rbst_pkg::pipe_t      stage_o
);
  import rbst_pkg::*;

  pipe_t stage_d, stage_q;

  always_comb begin
    stage_d = stage_i;
    for (int l = 0; l < NumLanes; l++) begin
      stage_d.lane[l] = div_step(stage_i.lane[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;
endmodule : rbst_div_step
`default_nettype wire

FILE: sv/rbst_resolve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_resolve
// Saturates and signs the quotients, then orders the slabs into a hit flag.
// ----------------------------------------------------------------------------
module rbst_resolve (
  input  wire logic            clk_i,
  input  wire logic            en_param_i,
  input  wire logic            en_hit_i,
  input  wire rbst_pkg::pipe_t stage_i,
  output logic                 hit_o
);
  import rbst_pkg::*;

  coord_t t_d [NumLanes];
  coord_t t_q [NumLanes];
  axis_t [NumAxes-1:0] axis_q;
  logic hit_d, hit_q;

  always_comb begin
    logic [QuotWidth-1:0] lim;
    logic [QuotWidth-1:0] qs;
    logic                 sat;
    for (int l = 0; l < NumLanes; l++) begin
      lim = stage_i.lane[l].neg ? {2'b01, {(QuotWidth-2){1'b0}}}
                                : {2'b00, {(QuotWidth-2){1'b1}}};
      sat = stage_i.lane[l].ovf || (stage_i.lane[l].acc > lim);
      qs  = sat ? lim : stage_i.lane[l].acc;
      t_d[l] = stage_i.lane[l].neg ? CoordWidth'(QuotWidth'(0) - qs) : CoordWidth'(qs);
    end
  end

  always_comb begin
    coord_t tmin, tmax, enter, leave;
    logic   miss, bounded;
    miss    = 1'b0;
    bounded = 1'b0;
    enter   = '0;
    leave   = '0;
    for (int k = 0; k < NumAxes; k++) begin
      tmin = (t_q[2*k] < t_q[2*k+1]) ? t_q[2*k] : t_q[2*k+1];
      tmax = (t_q[2*k] < t_q[2*k+1]) ? t_q[2*k+1] : t_q[2*k];
      if (axis_q[k].zero) begin
        if (!axis_q[k].in_range) begin
          miss = 1'b1;
        end
      end else if (!bounded) begin
        enter   = tmin;
        leave   = tmax;
        bounded = 1'b1;
      end else begin
        if (enter < tmin) enter = tmin;
        if (tmax < leave) leave = tmax;
      end
    end
    hit_d = !miss && (!bounded || ((enter < leave) && !leave[CoordWidth-1]));
  end

  always_ff @(posedge clk_i) begin
    if (en_param_i) begin
      t_q    <= t_d;
      axis_q <= stage_i.axis;
    end
    if (en_hit_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;
endmodule : rbst_resolve
`default_nettype wire

FILE: sv/ray_box_slab_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box hit test, slab method, signed Q16.16.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (ray origin, direction and box corners); each one
// yields exactly one response on rsp_o carrying hit, in request order.
// Each axis computes both plane parameters with two fixed-point dividers that
// resolve one quotient bit per stage; the six dividers run side by side.
// Stages: one prep stage, 33 divider stages, one saturate stage and one
// compare stage that feeds the output register: 36 register stages.
// Throughput is one request per cycle until a stalled rsp_o fills the pipe;
// the number of divider stages sets the pipe depth.
// Every stage carries its own valid bit, so bubbles close up: when rsp_o is
// stalled the pipe keeps taking requests until all 36 stages are full, and
// nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module ray_box_slab_test (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rbst_req_if.sink    req_i,
  rbst_rsp_if.source  rsp_o
);
  import rbst_pkg::*;

  localparam int NumStages = NumDivSteps + 3;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] load;
  pipe_t                pipe [NumDivSteps+1];
  coord_t               origin [3];
  coord_t               dir    [3];
  coord_t               low    [3];
  coord_t               high   [3];

  assign origin = '{req_i.origin_x, req_i.origin_y, req_i.origin_z};
  assign dir    = '{req_i.dir_x, req_i.dir_y, req_i.dir_z};
  assign low    = '{req_i.box_low_x, req_i.box_low_y, req_i.box_low_z};
  assign high   = '{req_i.box_high_x, req_i.box_high_y, req_i.box_high_z};

  // A stage loads when empty or when the stage after it moves on.
  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || rsp_o.ready;
    for (int s = NumStages - 2; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s+1];
    end
    valid_d[0] = req_i.valid;
    for (int s = 1; s < NumStages; s++) begin
      valid_d[s] = valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        if (load[s]) valid_q[s] <= valid_d[s];
      end
    end
  end

  rbst_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (load[0]),
    .origin_i(origin),
    .dir_i   (dir),
    .low_i   (low),
    .high_i  (high),
    .stage_o (pipe[0])
  );

  for (genvar g = 0; g < NumDivSteps; g++) begin : g_div
    rbst_div_step u_step (
      .clk_i  (clk_i),
      .en_i   (load[g+1]),
      .stage_i(pipe[g]),
      .stage_o(pipe[g+1])
    );
  end

  rbst_resolve u_resolve (
    .clk_i     (clk_i),
    .en_param_i(load[NumStages-2]),
    .en_hit_i  (load[NumStages-1]),
    .stage_i   (pipe[NumDivSteps]),
    .hit_o     (rsp_o.hit)
  );

  assign req_i.ready = load[0];
  assign rsp_o.valid = valid_q[NumStages-1];
endmodule : ray_box_slab_test
`default_nettype wire

FILE: tb/tb_ray_box_slab_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_test
// Drives random and directed ray/box requests with random idle bursts on both
// sides and checks every hit bit against an in-bench slab-test predictor.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test;
  import rbst_pkg::*;

  localparam int NumRandom = 400;
  localparam int WatchLimit = 2000;
  localparam int DrainCycles = 60;

  typedef struct packed {
    coord_t [2:0] org;
    coord_t [2:0] dir;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } ray_box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rbst_req_if req_if ();
  rbst_rsp_if rsp_if ();

  ray_box_slab_test u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  ray_box_t pending_q[$];
  logic     hit_q[$];
  int       errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_hits = 0;
  int       idle_cycles = 0;
  bit       quiet_phase = 1'b0;
  bit       stim_done = 1'b0;

  // Plane parameter ((plane - org) << FracBits) / dir, toward zero, saturated.
  function automatic logic signed [63:0] plane_t(coord_t plane, coord_t org, coord_t dir);
    logic signed [127:0] num;
    logic signed [127:0] q;
    num = ($signed({{96{plane[31]}}, plane}) - $signed({{96{org[31]}}, org})) <<< FracBits;
    q = num / $signed({{96{dir[31]}}, dir});
    if (q > 128'sh7fffffff) q = 128'sh7fffffff;
    if (q < -128'sh80000000) q = -128'sh80000000;
    return q[63:0];
  endfunction

  function automatic logic slab_hit(ray_box_t r);
    logic miss;
    logic bounded;
    logic signed [63:0] enter, leave, t1, t2, tmin, tmax;
    miss = 1'b0;
    bounded = 1'b0;
    enter = 0;
    leave = 0;
    for (int k = 0; k < NumAxes; k++) begin
      if (r.dir[k] == 0) begin
        if (r.org[k] < r.lo[k] || r.hi[k] < r.org[k]) miss = 1'b1;
      end else begin
        t1 = plane_t(r.lo[k], r.org[k], r.dir[k]);
        t2 = plane_t(r.hi[k], r.org[k], r.dir[k]);
        tmin = (t1 < t2) ? t1 : t2;
        tmax = (t1 < t2) ? t2 : t1;
        if (!bounded) begin
          enter = tmin;
          leave = tmax;
          bounded = 1'b1;
        end else begin
          if (enter < tmin) enter = tmin;
          if (tmax < leave) leave = tmax;
        end
      end
    end
    return !miss && (!bounded || (enter < leave && leave >= 0));
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
      2: return coord_t'(0);
      3: return {1'b1, 31'(0)};
      4: return {1'b0, {31{1'b1}}};
      default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
    endcase
  endfunction

  // Mostly well-posed: box around a point, ray aimed roughly at it.
  function automatic ray_box_t rand_item();
    ray_box_t r;
    coord_t c, h;
    for (int k = 0; k < NumAxes; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        r.org[k] = rand_coord();
        r.dir[k] = rand_coord();
        r.lo[k] = rand_coord();
        r.hi[k] = rand_coord();
      end else begin
        c = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        h = $urandom_range(0, 32'h00080000);
        r.lo[k] = c - h;
        r.hi[k] = c + h;
        r.org[k] = $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
        r.dir[k] = ($urandom_range(0, 7) == 0) ? coord_t'(0) :
                   (c - r.org[k]) + ($signed($urandom_range(0, 32'h00020000)) - 32'sh00010000);
      end
    end
    return r;
  endfunction

  function automatic ray_box_t uniform(coord_t o, coord_t d, coord_t l, coord_t h);
    ray_box_t r;
    for (int k = 0; k < NumAxes; k++) begin
      r.org[k] = o;
      r.dir[k] = d;
      r.lo[k] = l;
      r.hi[k] = h;
    end
    return r;
  endfunction

  initial begin
    ray_box_t r;
    coord_t mx, mn, one;
    mx = {1'b0, {31{1'b1}}};
    mn = {1'b1, 31'(0)};
    one = 32'sh00010000;
    // all-zero direction, inside, on the faces, outside
    pending_q.push_back(uniform(0, 0, -one, one));
    pending_q.push_back(uniform(one, 0, -one, one));
    pending_q.push_back(uniform(-one, 0, -one, one));
    pending_q.push_back(uniform(2 * one, 0, -one, one));
    // inverted box with zero and nonzero direction
    pending_q.push_back(uniform(0, 0, one, -one));
    pending_q.push_back(uniform(-4 * one, one, one, -one));
    // box ahead, behind, ray starting inside
    pending_q.push_back(uniform(-4 * one, one, -one, one));
    pending_q.push_back(uniform(4 * one, one, -one, one));
    pending_q.push_back(uniform(0, -one, -one, one));
    // saturating quotients at the extremes
    pending_q.push_back(uniform(mn, 1, mn, mx));
    pending_q.push_back(uniform(mx, -1, mn, mx));
    pending_q.push_back(uniform(mn, mx, mn, mx));
    pending_q.push_back(uniform(mx, mn, mn, mx));
    pending_q.push_back(uniform(mn, mn, mx, mx));
    pending_q.push_back(uniform(mx, mx, mn, mn));
    pending_q.push_back(uniform(-1, -1, -1, -1));
    // one axis zero direction, outside then inside, others hitting
    r = uniform(-4 * one, one, -one, one);
    r.dir[1] = 0;
    r.org[1] = 3 * one;
    pending_q.push_back(r);
    r.org[1] = 0;
    pending_q.push_back(r);
    // exit exactly equal to entry: grazing corner
    r = uniform(-one, one, 0, one);
    r.hi[2] = 0;
    pending_q.push_back(r);
    for (int i = 0; i < NumRandom; i++) begin
      pending_q.push_back(rand_item());
    end
  end

  // Request driver
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.origin_x <= '0; req_if.origin_y <= '0; req_if.origin_z <= '0;
      req_if.dir_x <= '0; req_if.dir_y <= '0; req_if.dir_z <= '0;
      req_if.box_low_x <= '0; req_if.box_low_y <= '0; req_if.box_low_z <= '0;
      req_if.box_high_x <= '0; req_if.box_high_y <= '0; req_if.box_high_z <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        n_sent++;
        void'(pending_q.pop_front());
      end
      quiet_phase <= (pending_q.size() < 60);
      if (req_if.valid && !req_if.ready) begin
        // hold the request
      end else if (src_gap > 0) begin
        src_gap--;
        req_if.valid <= 1'b0;
      end else if (!quiet_phase && req_if.valid && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(1, 10);
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.origin_x <= pending_q[0].org[0];
        req_if.origin_y <= pending_q[0].org[1];
        req_if.origin_z <= pending_q[0].org[2];
        req_if.dir_x <= pending_q[0].dir[0];
        req_if.dir_y <= pending_q[0].dir[1];
        req_if.dir_z <= pending_q[0].dir[2];
        req_if.box_low_x <= pending_q[0].lo[0];
        req_if.box_low_y <= pending_q[0].lo[1];
        req_if.box_low_z <= pending_q[0].lo[2];
        req_if.box_high_x <= pending_q[0].hi[0];
        req_if.box_high_y <= pending_q[0].hi[1];
        req_if.box_high_z <= pending_q[0].hi[2];
      end else begin
        req_if.valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // Predict at acceptance, in request order
  always @(posedge clk_i) begin
    ray_box_t r;
    if (rst_ni && req_if.valid && req_if.ready) begin
      r.org = {req_if.origin_z, req_if.origin_y, req_if.origin_x};
      r.dir = {req_if.dir_z, req_if.dir_y, req_if.dir_x};
      r.lo = {req_if.box_low_z, req_if.box_low_y, req_if.box_low_x};
      r.hi = {req_if.box_high_z, req_if.box_high_y, req_if.box_high_x};
      hit_q.push_back(slab_hit(r));
    end
  end

  // Response monitor and stall generator
  int snk_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: response with nothing expected, actual hit=%0b", $time, rsp_if.hit);
          errors++;
        end else begin
          want = hit_q.pop_front();
          if (want !== rsp_if.hit) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, rsp_if.hit);
            errors++;
          end
          n_checked++;
          if (want) n_hits++;
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(1, 10);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any accepted request or response
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && hit_q.size() == 0);
        repeat (DrainCycles) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= WatchLimit);
      end
    join_any
    if (idle_cycles >= WatchLimit || hit_q.size() != 0) begin
      $display("simulation failed");
    end else begin
      $display("Checked %0d responses for %0d requests, %0d hits and %0d misses.",
               n_checked, n_sent, n_hits, n_checked - n_hits);
      if (errors == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule : tb_ray_box_slab_test
